FILE: design/signed_add_sub_mul_div_alu_top_defines.svh
// assertion macros shared by the alu top level
`ifndef SIGNED_ADD_SUB_MUL_DIV_ALU_TOP_DEFINES_SVH
`define SIGNED_ADD_SUB_MUL_DIV_ALU_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SALU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SALU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/salu_pkg.sv
package salu_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    // operation codes of the func field
    typedef enum logic [1:0] {
        FN_ADD = 2'd0,
        FN_SUB = 2'd1,
        FN_MUL = 2'd2,
        FN_DIV = 2'd3
    } func_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDSUB,
        ST_MUL,
        ST_DIV,
        ST_SIGN,
        ST_DONE
    } state_t;

    // what the shared adder does this cycle
    typedef enum logic [2:0] {
        UOP_HOLD,
        UOP_ADDSUB,
        UOP_MUL,
        UOP_DIV,
        UOP_SIGN
    } uop_t;

    // sequencer to datapath
    typedef struct packed {
        logic load;
        uop_t uop;
        logic out_load;
    } ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic b_zero;
    } status_t;

endpackage

FILE: design/salu_datapath.sv
module salu_datapath
    import salu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic [1:0]                   func,
    input  logic signed [DATA_WIDTH-1:0] operand_a,
    input  logic signed [DATA_WIDTH-1:0] operand_b,
    input  ctrl_t                        ctrl,
    output status_t                      status,
    output logic signed [DATA_WIDTH-1:0] result,
    output logic [DATA_WIDTH-2:0]        remainder_mag,
    output logic                         div_by_zero
);

    localparam int W = DATA_WIDTH;

    func_t        func_reg, func_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] opa_reg, opa_next;
    logic [W-1:0] opb_reg, opb_next;
    logic         neg_reg, neg_next;
    logic         dz_reg, dz_next;

    logic [W-1:0] result_reg, result_next;
    logic [W-2:0] rem_reg, rem_next;
    logic         dzo_reg, dzo_next;

    logic [W-1:0] mag_a, mag_b;
    logic [W-1:0] unit_x, unit_y;
    logic         unit_sub;
    logic [W:0]   unit_sum;

    assign mag_a = operand_a[W-1] ? (~operand_a + W'(1)) : operand_a;
    assign mag_b = operand_b[W-1] ? (~operand_b + W'(1)) : operand_b;
    assign status.b_zero = (operand_b == '0);

    // the one shared adder / subtractor
    always_comb
    begin
        unit_x   = '0;
        unit_y   = '0;
        unit_sub = 1'b0;
        unique case (ctrl.uop)
            UOP_HOLD:
            begin
                unit_x = '0;
            end
            UOP_ADDSUB:
            begin
                unit_x   = opa_reg;
                unit_y   = opb_reg;
                unit_sub = (func_reg == FN_SUB);
            end
            UOP_MUL:
            begin
                unit_x = acc_reg;
                unit_y = opb_reg[0] ? opa_reg : '0;
            end
            UOP_DIV:
            begin
                unit_x   = {acc_reg[W-2:0], opa_reg[W-1]};
                unit_y   = opb_reg;
                unit_sub = 1'b1;
            end
            UOP_SIGN:
            begin
                unit_y   = opa_reg;
                unit_sub = neg_reg;
            end
        endcase
        unit_sum = {1'b0, unit_x} + {1'b0, (unit_sub ? ~unit_y : unit_y)}
                 + {{W{1'b0}}, unit_sub};
    end

    always_comb
    begin
        func_next = func_reg;
        acc_next  = acc_reg;
        opa_next  = opa_reg;
        opb_next  = opb_reg;
        neg_next  = neg_reg;
        dz_next   = dz_reg;
        if (ctrl.load)
        begin
            func_next = func_t'(func);
            acc_next  = '0;
            if (func_t'(func) == FN_DIV)
            begin
                opa_next = mag_a;
                opb_next = mag_b;
                neg_next = operand_a[W-1] ^ operand_b[W-1];
                dz_next  = status.b_zero;
            end
            else
            begin
                opa_next = operand_a;
                opb_next = operand_b;
                neg_next = 1'b0;
                dz_next  = 1'b0;
            end
        end
        else
        begin
            unique case (ctrl.uop)
                UOP_HOLD:
                begin
                    acc_next = acc_reg;
                end
                UOP_ADDSUB:
                begin
                    acc_next = unit_sum[W-1:0];
                end
                UOP_MUL:
                begin
                    acc_next = unit_sum[W-1:0];
                    opa_next = {opa_reg[W-2:0], 1'b0};
                    opb_next = {1'b0, opb_reg[W-1:1]};
                end
                UOP_DIV:
                begin
                    // carry out set means no borrow: the divisor fits
                    acc_next = unit_sum[W] ? unit_sum[W-1:0] : unit_x;
                    opa_next = {opa_reg[W-2:0], unit_sum[W]};
                end
                UOP_SIGN:
                begin
                    opa_next = unit_sum[W-1:0];
                end
            endcase
        end
    end

    // output register
    always_comb
    begin
        result_next = result_reg;
        rem_next    = rem_reg;
        dzo_next    = dzo_reg;
        if (ctrl.out_load)
        begin
            dzo_next = dz_reg;
            if (dz_reg)
            begin
                result_next = '0;
                rem_next    = '0;
            end
            else if (func_reg == FN_DIV)
            begin
                result_next = opa_reg;
                rem_next    = acc_reg[W-2:0];
            end
            else
            begin
                result_next = acc_reg;
                rem_next    = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        acc_reg    <= acc_next;
        opa_reg    <= opa_next;
        opb_reg    <= opb_next;
        neg_reg    <= neg_next;
        dz_reg     <= dz_next;
        result_reg <= result_next;
        rem_reg    <= rem_next;
        dzo_reg    <= dzo_next;
    end

    assign result        = result_reg;
    assign remainder_mag = rem_reg;
    assign div_by_zero   = dzo_reg;

endmodule

FILE: design/salu_ctrl.sv
module salu_ctrl
    import salu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    output logic       out_valid,
    input  logic       out_stall,
    input  status_t    status,
    output ctrl_t      ctrl
);

    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ctrl.load     = 1'b0;
        ctrl.uop      = UOP_HOLD;
        ctrl.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load = 1'b1;
                    cnt_next  = '0;
                    unique case (func_t'(func))
                        FN_ADD, FN_SUB: state_next = ST_ADDSUB;
                        FN_MUL:         state_next = ST_MUL;
                        FN_DIV:         state_next = status.b_zero ? ST_DONE : ST_DIV;
                    endcase
                end
            end
            ST_ADDSUB:
            begin
                ctrl.uop   = UOP_ADDSUB;
                state_next = ST_DONE;
            end
            ST_MUL:
            begin
                ctrl.uop = UOP_MUL;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                ctrl.uop = UOP_DIV;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                ctrl.uop   = UOP_SIGN;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: design/signed_add_sub_mul_div_alu_top.sv
// signed integer alu: add, subtract, shift-add multiply, restoring divide
// input channel: in_valid / in_stall with func, operand_a, operand_b; a transfer
//   happens on a clock edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with result, remainder_mag, div_by_zero
// one transfer in gives exactly one transfer out, in order
// order of work: add and subtract take one pass through the shared adder,
//   multiply and divide one pass per bit, divide then a sign pass; a
//   divide by zero goes straight to the result
// throughput: one item at a time; in_stall is high from the cycle after a
//   transfer until the result moves into the output register
// the output register lets a new item start while the last result waits
// a stalled receiver holds the result; a finished item then waits in the
//   sequencer until the output register frees up, and input stays stalled
// reset (rst_n, async active low) empties the sequencer and the output
//   register; no result is pending afterward
// divide works on magnitudes, quotient sign is the xor of the operand signs
module signed_add_sub_mul_div_alu_top
    import salu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   func,
    input  logic signed [DATA_WIDTH-1:0] operand_a,
    input  logic signed [DATA_WIDTH-1:0] operand_b,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] result,
    output logic [DATA_WIDTH-2:0]        remainder_mag,
    output logic                         div_by_zero
);

`include "signed_add_sub_mul_div_alu_top_defines.svh"

    ctrl_t   ctrl;
    status_t status;

    // sequencer: state, bit counter, output valid
    salu_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .ctrl      (ctrl)
    );

    // operand registers, shared adder and output register
    salu_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .func          (func),
        .operand_a     (operand_a),
        .operand_b     (operand_b),
        .ctrl          (ctrl),
        .status        (status),
        .result        (result),
        .remainder_mag (remainder_mag),
        .div_by_zero   (div_by_zero)
    );

    // once an item is taken the block is busy the next cycle
    `SALU_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall,
        "not busy after input transfer")

    // the new result cannot come out in the cycle right after its transfer in
    `SALU_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall && !out_valid,
        !out_valid, "result appeared too early")

    // divide by zero always reports zero quotient and remainder
    `SALU_ASSERT_NOW(a_dz_zeroes, out_valid && div_by_zero,
        result == '0 && remainder_mag == '0, "divide by zero result not cleared")

endmodule

FILE: tb/sv/tb_signed_add_sub_mul_div_alu_top.sv
`timescale 1ns / 100ps

module tb_signed_add_sub_mul_div_alu_top;
    import salu_pkg::*;

    localparam int DW         = DATA_WIDTH_DEF;
    localparam int RAND_ITEMS = 600;
    // receiver hold-off long enough that the sequencer and output register both fill
    localparam int LONG_HOLD  = 300;
    // longest latency is a divide; the drain runs past it
    localparam int DRAIN      = DW + 20;
    // timeout: several times the slowest legal run at a 20 ns clock
    localparam longint LIMIT_NS = 64'd10_000_000;

    // one result transfer
    typedef struct packed {
        logic [DW-1:0] res;
        logic [DW-2:0] rem;
        logic          dz;
    } alu_out_t;

    // one row of the directed table; typed rows carry their answer
    typedef struct packed {
        func_t         f;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        logic          typed;
        alu_out_t      want;
    } alu_row_t;

    localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] ONES = {DW{1'b1}};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            func;
    logic signed [DW-1:0]  operand_a;
    logic signed [DW-1:0]  operand_b;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [DW-1:0]  result;
    logic [DW-2:0]         remainder_mag;
    logic                  div_by_zero;

    alu_out_t pending_results[$];
    int       err_count = 0;
    // set by the stimulus, picked up and cleared by the receiver
    bit       long_hold_req = 1'b0;

    // directed table: wrap points, every operation, zero divisor,
    // minimum dividend and minimum divisor
    alu_row_t dir_rows [25] = '{
        '{FN_ADD, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 31'h0, 1'b0}},
        '{FN_ADD, MAXV,          32'h0000_0001, 1'b1, '{32'h8000_0000, 31'h0, 1'b0}},
        '{FN_ADD, MINV,          MINV,          1'b1, '{32'h0000_0000, 31'h0, 1'b0}},
        '{FN_ADD, ONES,          32'h0000_0001, 1'b1, '{32'h0000_0000, 31'h0, 1'b0}},
        '{FN_ADD, 32'h5555_5555, 32'haaaa_aaab, 1'b0, '0},
        '{FN_SUB, MINV,          32'h0000_0001, 1'b1, '{32'h7fff_ffff, 31'h0, 1'b0}},
        '{FN_SUB, 32'h0000_0000, MINV,          1'b1, '{32'h8000_0000, 31'h0, 1'b0}},
        '{FN_SUB, 32'h0000_0005, 32'h0000_0007, 1'b0, '0},
        '{FN_MUL, MAXV,          MAXV,          1'b0, '0},
        '{FN_MUL, 32'hffff_fffd, 32'h0000_0007, 1'b0, '0},
        '{FN_MUL, 32'h1234_5678, ONES,          1'b0, '0},
        '{FN_MUL, MINV,          ONES,          1'b1, '{32'h8000_0000, 31'h0, 1'b0}},
        '{FN_MUL, ONES,          ONES,          1'b1, '{32'h0000_0001, 31'h0, 1'b0}},
        '{FN_DIV, 32'h0000_0007, 32'h0000_0000, 1'b1, '{32'h0000_0000, 31'h0, 1'b1}},
        '{FN_DIV, MINV,          32'h0000_0000, 1'b1, '{32'h0000_0000, 31'h0, 1'b1}},
        '{FN_DIV, MINV,          32'h0000_0001, 1'b1, '{32'h8000_0000, 31'h0, 1'b0}},
        '{FN_DIV, MINV,          ONES,          1'b1, '{32'h8000_0000, 31'h0, 1'b0}},
        '{FN_DIV, 32'h0000_0007, MINV,          1'b1, '{32'h0000_0000, 31'h7, 1'b0}},
        '{FN_DIV, MINV,          MINV,          1'b1, '{32'h0000_0001, 31'h0, 1'b0}},
        '{FN_DIV, MAXV,          MINV,          1'b1, '{32'h0000_0000, 31'h7fff_ffff, 1'b0}},
        '{FN_DIV, 32'hffff_fff9, 32'h0000_0002, 1'b0, '0},
        '{FN_DIV, 32'h0000_0007, 32'hffff_fffe, 1'b0, '0},
        '{FN_DIV, 32'hffff_fff9, 32'hffff_fffe, 1'b0, '0},
        '{FN_DIV, MAXV,          32'h0000_0001, 1'b0, '0},
        '{FN_DIV, 32'h0000_0000, 32'hffff_fffb, 1'b0, '0}
    };

    signed_add_sub_mul_div_alu_top #(
        .DATA_WIDTH (DW)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .operand_a     (operand_a),
        .operand_b     (operand_b),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result        (result),
        .remainder_mag (remainder_mag),
        .div_by_zero   (div_by_zero)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // expected alu output: wrapped add/sub/mul, magnitude divide with xor sign
    function automatic alu_out_t compute_alu_result(input func_t f,
                                                    input logic [DW-1:0] a,
                                                    input logic [DW-1:0] b);
        alu_out_t      r;
        logic [DW-1:0] mag_a;
        logic [DW-1:0] mag_b;
        logic [DW-1:0] quo;
        logic [DW-1:0] rm;
        r = '0;
        case (f)
            FN_ADD: r.res = a + b;
            FN_SUB: r.res = a - b;
            // low word of the product is the same for signed and unsigned operands
            FN_MUL: r.res = a * b;
            default:
            begin
                // minimum value negates to itself, read as unsigned 2^(DW-1)
                mag_a = a[DW-1] ? -a : a;
                mag_b = b[DW-1] ? -b : b;
                if (mag_b == '0)
                begin
                    r.dz = 1'b1;
                end
                else
                begin
                    quo   = mag_a / mag_b;
                    rm    = mag_a % mag_b;
                    r.rem = rm[DW-2:0];
                    r.res = (a[DW-1] ^ b[DW-1]) ? -quo : quo;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [DW-1:0] got,
                                   input logic [DW-1:0] want);
        $display("%0t: mismatch on %s, got %0h, want %0h", $time, field, got, want);
        err_count++;
    endtask

    // corners, small values around zero, or full-range random
    function automatic logic [DW-1:0] rand_operand();
        logic [DW-1:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       v = '0;
                    1:       v = 1;
                    2:       v = ONES;
                    3:       v = MINV;
                    default: v = MAXV;
                endcase
            end
            1, 2:    v = $urandom_range(0, 40) - 20;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // offer one item, hold it until the transfer, then queue its answer
    task automatic send_op(input func_t f, input logic [DW-1:0] a,
                           input logic [DW-1:0] b, input logic typed,
                           input alu_out_t want);
        in_valid  <= 1'b1;
        func      <= f;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(typed ? want : compute_alu_result(f, a, b));
    endtask

    // output side: every transfer is checked against the oldest answer
    always @(posedge clk)
    begin
        alu_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing pending", result, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result !== want.res)
                    report_mismatch("result", result, want.res);
                if (remainder_mag !== want.rem)
                    report_mismatch("remainder_mag", DW'(remainder_mag), DW'(want.rem));
                if (div_by_zero !== want.dz)
                    report_mismatch("div_by_zero", DW'(div_by_zero), DW'(want.dz));
            end
        end
    end

    // receiver: stretches of free flow, random stalls, heavy stalls and a
    // periodic pattern, plus one long hold-off on request
    initial
    begin : receiver
        int seg;
        int mode;
        int k;
        int hold_cnt;
        out_stall = 1'b0;
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_cnt = 0;
                while (hold_cnt < LONG_HOLD)
                begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                    hold_cnt++;
                end
            end
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(5, 60);
            for (k = 0; k < seg; k++)
            begin
                @(posedge clk);
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= $urandom_range(0, 1);
                    2:       out_stall <= ($urandom_range(0, 9) < 8);
                    default: out_stall <= (k % 3 != 0);
                endcase
            end
        end
    end

    // sender: directed table first, then random bursts with random gaps
    initial
    begin : stimulus
        int    n;
        int    burst_left;
        int    gap;
        func_t f;
        in_valid  = 1'b0;
        func      = FN_ADD;
        operand_a = '0;
        operand_b = '0;
        rst_n     = 1'b0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_op(dir_rows[i].f, dir_rows[i].a, dir_rows[i].b,
                    dir_rows[i].typed, dir_rows[i].want);

        burst_left = 0;
        for (n = 0; n < RAND_ITEMS; n++)
        begin
            // receiver goes quiet while items keep coming, so input stalls
            if (n == 100)
                long_hold_req = 1'b1;
            if (n == 350)
            begin
                // sender pause until the block has drained completely
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
            end
            else if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(0, 8);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap)
                        @(posedge clk);
                end
            end
            if (burst_left > 0)
                burst_left--;
            f = func_t'($urandom_range(0, 3));
            send_op(f, rand_operand(), rand_operand(), 1'b0, '0);
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        // let any stray transfer show up before the verdict
        repeat (DRAIN)
            @(posedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
